@@ hdl/sipq_pkg.sv @@
`default_nettype none

package sipq_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int TAG_W = 4;
    localparam int KEY_W = 4;
    localparam int OCC_W = 8;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
        logic [KEY_W-1:0] key;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
        t_cnt   count;
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/sipq_cell.sv @@
`default_nettype none

module sipq_cell (
    input  wire logic             i_clk,
    input  wire sipq_pkg::t_idx   i_idx,
    input  wire sipq_pkg::t_cmd   i_cmd,
    input  wire sipq_pkg::t_entry i_left,
    input  wire logic             i_left_gt,
    input  wire sipq_pkg::t_entry i_right,
    output sipq_pkg::t_entry      o_entry,
    output logic                  o_gt
);

    sipq_pkg::t_entry r_entry;
    sipq_pkg::t_entry n_entry;
    logic             w_occ;
    logic             w_at_end;

    // cell holds a live entry when its position is below the count
    assign w_occ    = sipq_pkg::t_cnt'(i_idx) < i_cmd.count;
    assign w_at_end = sipq_pkg::t_cnt'(i_idx) == i_cmd.count;
    assign o_gt     = w_occ && (r_entry.key > i_cmd.entry.key);

    always_comb begin
        n_entry = r_entry;
        priority if (i_cmd.push) begin
            // larger keys shift back, the new item lands at the first of them
            priority if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || w_at_end) begin
                n_entry = i_cmd.entry;
            end else begin
                n_entry = r_entry;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

@@ hdl/sorted_insert_priority_queue.sv @@
// sorted_insert_priority_queue
// bounded priority queue built as a chain of cells, kept sorted by key
// input channel (i_valid / o_ready): i_func selects push (tag + key) or pop
// output channel (o_valid / i_ready): one item per accepted input with
//   status, popped entry (zeros unless popped), occupancy and empty flag
// every cell compares its key against the broadcast key and either holds,
//   takes the new entry or takes its left neighbor (push), or takes its
//   right neighbor (pop); the whole chain updates together
// the result item is registered and valid in the cycle after the input is accepted
// throughput: one item per cycle unless the receiver stalls; the output
//   register is refilled in the same cycle it is drained
// equal keys leave first in, first out; a push into a full queue is dropped
//   with status full, a pop on an empty queue returns status empty
// reset: synchronous, active low; clears the count and the output valid,
//   cell contents are left as they are and never read until written
// receiver stall: while o_valid is high and i_ready is low, the result holds
//   and o_ready drops, so no further item is taken
`default_nettype none

module sorted_insert_priority_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_func,
    input  wire logic [3:0] i_entry_row,
    input  wire logic [3:0] i_entry_col,
    input  wire logic [3:0] i_entry_key,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [3:0]      o_out_row,
    output logic [3:0]      o_out_col,
    output logic [3:0]      o_out_key,
    output logic [7:0]      o_occupancy,
    output logic            o_is_empty
);

    localparam int CAP = sipq_pkg::CAPACITY;

    // occupancy counter
    sipq_pkg::t_cnt    r_count;
    sipq_pkg::t_cnt    n_count;

    // output register
    logic              r_o_valid;
    sipq_pkg::t_status r_status;
    sipq_pkg::t_entry  r_out;
    logic              r_is_empty;

    logic              w_acc;
    logic              w_full;
    logic              w_empty;
    sipq_pkg::t_cmd    w_cmd;

    sipq_pkg::t_entry  w_entry [CAP];
    logic              w_gt    [CAP];

    assign o_ready = !r_o_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_full  = r_count == sipq_pkg::t_cnt'(CAP);
    assign w_empty = r_count == '0;

    // command broadcast to the chain
    assign w_cmd.push        = w_acc && (i_func == sipq_pkg::FUNC_PUSH) && !w_full;
    assign w_cmd.pop         = w_acc && (i_func == sipq_pkg::FUNC_POP) && !w_empty;
    assign w_cmd.entry.row   = i_entry_row;
    assign w_cmd.entry.col   = i_entry_col;
    assign w_cmd.entry.key   = i_entry_key;
    assign w_cmd.count       = r_count;

    // the chain: cell zero is the head, the smallest key
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        sipq_pkg::t_entry w_left;
        sipq_pkg::t_entry w_right;
        logic             w_left_gt;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        sipq_cell u_cell (
            .i_clk     (i_clk),
            .i_idx     (sipq_pkg::t_idx'(g)),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (w_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted item
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out      <= w_cmd.pop ? w_entry[0] : '0;
            r_is_empty <= n_count == '0;
            unique case (i_func)
                sipq_pkg::FUNC_PUSH: begin
                    r_status <= w_full ? sipq_pkg::ST_FULL : sipq_pkg::ST_PUSHED;
                end
                default: begin
                    r_status <= w_empty ? sipq_pkg::ST_EMPTY : sipq_pkg::ST_POPPED;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_status;
    assign o_out_row   = r_out.row;
    assign o_out_col   = r_out.col;
    assign o_out_key   = r_out.key;
    assign o_occupancy = 8'(r_count);
    assign o_is_empty  = r_is_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sipq_pkg::t_cnt'(CAP))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the count");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_is_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.pop && (r_count > sipq_pkg::t_cnt'(1)))
        |=> (r_out.key <= w_entry[0].key))
        else $error("popped key larger than new head");
`endif

endmodule

`default_nettype wire
